[src/irgc_pkg.sv]
// ----------------------------------------------------------------------------
// irgc_pkg
// shared types and constants of the iterative rational gain correction
// ----------------------------------------------------------------------------
package irgc_pkg;

    localparam int XW    = 20;   // energy, unsigned q8.12
    localparam int FW    = 20;   // factor / scale, signed q4.16
    localparam int RW    = 25;   // reference value, signed q.12
    localparam int COEFW = 48;   // a, b, c packed as three q8.8 halves
    localparam int CFGIW = 3;    // configuration index width

    localparam logic signed [FW-1:0] Q16_MAX = 20'sh7FFFF;
    localparam logic signed [FW-1:0] Q16_MIN = 20'sh80000;
    localparam logic signed [FW-1:0] ONE_Q16 = 20'sh10000;

    // configuration register indexes
    localparam logic [CFGIW-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFGIW-1:0] CFG_ITER   = 3'd1;
    localparam logic [CFGIW-1:0] CFG_COEF0  = 3'd2;
    localparam logic [CFGIW-1:0] CFG_COEF1  = 3'd3;
    localparam logic [CFGIW-1:0] CFG_COEF2  = 3'd4;
    localparam logic [CFGIW-1:0] CFG_COEF3  = 3'd5;

    // state of one item as it moves from pass to pass
    typedef struct packed {
        logic [XW-1:0]        x;
        logic signed [FW-1:0] scale;
        logic signed [RW-1:0] r;
        logic                 sat;
        logic                 done;
    } ctx_t;

endpackage

[src/irgc_div.sv]
// ----------------------------------------------------------------------------
// irgc_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module irgc_div #(
    parameter int NW = 50,
    parameter int DW = 25,
    parameter int QW = 20,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_v,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_pay,
    output logic          out_v,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] out_pay
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic          v_reg    [0:QW];
    logic [DW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] nq_reg   [0:QW];
    logic [DW-1:0] d_reg    [0:QW];
    logic          ovf_reg  [0:QW];
    logic [SW-1:0] pay_reg  [0:QW];

    logic [DW-1:0] rem_next [0:QW];
    logic [QW-1:0] nq_next  [0:QW];

    logic [CW-1:0] hi_c;
    logic [CW-1:0] den_c;
    logic          ovf_init;

    // quotient wider than QW bits when the top part already reaches the divisor
    assign hi_c     = CW'(num[NW-1:QW]);
    assign den_c    = CW'(den);
    assign ovf_init = (hi_c >= den_c);

    always_comb
    begin
        logic [DW:0] trial;
        logic [DW:0] dd;
        rem_next[0] = hi_c[DW-1:0];
        nq_next[0]  = num[QW-1:0];
        for (int k = 0; k < QW; k++)
        begin
            trial = {rem_reg[k], nq_reg[k][QW-1]};
            dd    = {1'b0, d_reg[k]};
            if (trial >= dd)
            begin
                rem_next[k+1] = DW'(trial - dd);
                nq_next[k+1]  = {nq_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1] = trial[DW-1:0];
                nq_next[k+1]  = {nq_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_v;
            for (int k = 0; k < QW; k++)
                v_reg[k+1] <= v_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem_next[0];
            nq_reg[0]  <= nq_next[0];
            d_reg[0]   <= den;
            ovf_reg[0] <= ovf_init;
            pay_reg[0] <= in_pay;
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k+1] <= rem_next[k+1];
                nq_reg[k+1]  <= nq_next[k+1];
                d_reg[k+1]   <= d_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                pay_reg[k+1] <= pay_reg[k];
            end
        end
    end

    assign out_v   = v_reg[QW];
    assign quo     = nq_reg[QW];
    assign ovf     = ovf_reg[QW];
    assign out_pay = pay_reg[QW];

endmodule

[src/irgc_pass.sv]
// ----------------------------------------------------------------------------
// irgc_pass
// one correction pass: scale *= (r + a + b/r) / (r + c), then r = x * scale
// ----------------------------------------------------------------------------
module irgc_pass (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       active,
    input  logic [irgc_pkg::COEFW-1:0] coef,
    input  logic                       in_v,
    input  irgc_pkg::ctx_t             in_ctx,
    output logic                       out_v,
    output irgc_pkg::ctx_t             out_ctx
);

    import irgc_pkg::*;

    localparam int CTXW = $bits(ctx_t);

    // coefficient fields
    logic signed [15:0] coef_a;
    logic        [15:0] coef_b;
    logic signed [15:0] coef_c;
    logic signed [19:0] a16;
    logic signed [19:0] c16;

    assign coef_a = $signed(coef[15:0]);
    assign coef_b = coef[31:16];
    assign coef_c = $signed(coef[47:32]);
    assign a16    = $signed({coef_a, 4'b0000});
    assign c16    = $signed({coef_c, 4'b0000});

    // b / r
    ctx_t              ctx_a;
    logic              b_neg;
    logic              r_neg;
    logic [15:0]       b_mag;
    logic [RW-1:0]     r_u;
    logic [RW-1:0]     r_mag;
    logic              d1_v;
    logic [31:0]       d1_quo;
    logic              d1_ovf;
    logic [CTXW:0]     d1_pay;

    always_comb
    begin
        ctx_a      = in_ctx;
        ctx_a.done = in_ctx.done | ~active | (in_ctx.r == '0);
        b_neg      = coef_b[15];
        b_mag      = b_neg ? (~coef_b + 16'd1) : coef_b;
        r_u        = in_ctx.r;
        r_neg      = r_u[RW-1];
        r_mag      = r_neg ? (~r_u + 1'b1) : r_u;
    end

    irgc_div #(
        .NW (33),
        .DW (RW),
        .QW (32),
        .SW (CTXW + 1)
    ) u_div_br (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (in_v),
        .num     ({1'b0, b_mag, 16'h0000}),
        .den     (r_mag),
        .in_pay  ({ctx_a, b_neg ^ r_neg}),
        .out_v   (d1_v),
        .quo     (d1_quo),
        .ovf     (d1_ovf),
        .out_pay (d1_pay)
    );

    // numerator and denominator
    ctx_t               ctx_b;
    logic signed [32:0] bq_s;
    logic signed [32:0] bq_val;
    logic signed [34:0] num_next;
    logic signed [25:0] den_next;
    logic               s1_v_reg;
    ctx_t               s1_ctx_reg;
    logic signed [34:0] s1_num_reg;
    logic signed [25:0] s1_den_reg;

    always_comb
    begin
        ctx_b    = d1_pay[CTXW:1];
        bq_s     = $signed({1'b0, d1_quo});
        bq_val   = d1_pay[0] ? -bq_s : bq_s;
        num_next = 35'(ctx_b.r) + 35'(a16) + 35'(bq_val);
        den_next = 26'(ctx_b.r) + 26'(c16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= d1_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctx_reg <= ctx_b;
            s1_num_reg <= num_next;
            s1_den_reg <= den_next;
        end
    end

    // num / den, zero denominator ends the loop
    ctx_t          ctx_c;
    logic          n_neg;
    logic          dn_neg;
    logic [34:0]   n_u;
    logic [34:0]   n_abs;
    logic [25:0]   dn_u;
    logic [25:0]   dn_abs;
    logic          d2_v;
    logic [FW-1:0] d2_quo;
    logic          d2_ovf;
    logic [CTXW:0] d2_pay;

    always_comb
    begin
        ctx_c  = s1_ctx_reg;
        n_u    = s1_num_reg;
        n_neg  = n_u[34];
        n_abs  = n_neg ? (~n_u + 35'd1) : n_u;
        dn_u   = s1_den_reg;
        dn_neg = dn_u[25];
        dn_abs = dn_neg ? (~dn_u + 26'd1) : dn_u;
        if (!s1_ctx_reg.done && (s1_den_reg == '0))
        begin
            ctx_c.done  = 1'b1;
            ctx_c.sat   = 1'b1;
            ctx_c.scale = (n_neg != s1_ctx_reg.scale[FW-1]) ? Q16_MIN : Q16_MAX;
        end
    end

    irgc_div #(
        .NW (50),
        .DW (25),
        .QW (FW),
        .SW (CTXW + 1)
    ) u_div_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (s1_v_reg),
        .num     ({n_abs[33:0], 16'h0000}),
        .den     (dn_abs[24:0]),
        .in_pay  ({ctx_c, n_neg ^ dn_neg}),
        .out_v   (d2_v),
        .quo     (d2_quo),
        .ovf     (d2_ovf),
        .out_pay (d2_pay)
    );

    // clamp of the pass quotient
    ctx_t                 ctx_d;
    logic signed [FW-1:0] q_next;
    logic                 q_sat;
    logic                 s2_v_reg;
    ctx_t                 s2_ctx_reg;
    logic signed [FW-1:0] s2_q_reg;

    always_comb
    begin
        ctx_d = d2_pay[CTXW:1];
        q_sat = 1'b0;
        if (d2_pay[0])
        begin
            if (d2_ovf || (d2_quo > 20'h80000))
            begin
                q_next = Q16_MIN;
                q_sat  = 1'b1;
            end
            else
                q_next = $signed(~d2_quo + 20'd1);
        end
        else
        begin
            if (d2_ovf || (d2_quo > 20'h7FFFF))
            begin
                q_next = Q16_MAX;
                q_sat  = 1'b1;
            end
            else
                q_next = $signed(d2_quo);
        end
        if (!ctx_d.done && q_sat)
            ctx_d.sat = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= d2_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ctx_reg <= ctx_d;
            s2_q_reg   <= q_next;
        end
    end

    // scale * q
    logic signed [39:0] prod_next;
    logic               s3_v_reg;
    ctx_t               s3_ctx_reg;
    logic signed [39:0] s3_prod_reg;

    assign prod_next = s2_ctx_reg.scale * s2_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (adv)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ctx_reg  <= s2_ctx_reg;
            s3_prod_reg <= prod_next;
        end
    end

    // floor shift and clamp of the new scale
    ctx_t               ctx_e;
    logic signed [23:0] sh;
    logic               s4_v_reg;
    ctx_t               s4_ctx_reg;

    always_comb
    begin
        ctx_e = s3_ctx_reg;
        sh    = s3_prod_reg[39:16];
        if (!s3_ctx_reg.done)
        begin
            if (sh > 24'sd524287)
            begin
                ctx_e.scale = Q16_MAX;
                ctx_e.sat   = 1'b1;
            end
            else if (sh < -24'sd524288)
            begin
                ctx_e.scale = Q16_MIN;
                ctx_e.sat   = 1'b1;
            end
            else
                ctx_e.scale = sh[FW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (adv)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s4_ctx_reg <= ctx_e;
    end

    // x * scale
    logic signed [40:0] prod2_next;
    logic               s5_v_reg;
    ctx_t               s5_ctx_reg;
    logic signed [40:0] s5_prod2_reg;

    assign prod2_next = $signed({1'b0, s4_ctx_reg.x}) * s4_ctx_reg.scale;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else if (adv)
            s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_ctx_reg   <= s4_ctx_reg;
            s5_prod2_reg <= prod2_next;
        end
    end

    // new reference value
    ctx_t ctx_f;
    logic out_v_reg;
    ctx_t out_ctx_reg;

    always_comb
    begin
        ctx_f = s5_ctx_reg;
        if (!s5_ctx_reg.done)
            ctx_f.r = s5_prod2_reg[40:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= s5_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_ctx_reg <= ctx_f;
    end

    assign out_v   = out_v_reg;
    assign out_ctx = out_ctx_reg;

    // pipeline holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && out_v_reg) |=> (out_v_reg && $stable(out_ctx_reg)))
        else $error("pass output changed while held");

    // a finished item stays finished
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s5_v_reg && s5_ctx_reg.done) |=> out_ctx_reg.done)
        else $error("done flag lost in pass");

    // saturation is sticky
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s4_v_reg && s4_ctx_reg.sat) |=> (s5_v_reg && s5_ctx_reg.sat))
        else $error("saturation flag lost in pass");

endmodule

[src/iterative_rational_gain_correction.sv]
// ----------------------------------------------------------------------------
// iterative_rational_gain_correction
// energy in, nonlinearity correction factor out, passes fully unrolled
// ----------------------------------------------------------------------------
// usage
//   input channel: energy (unsigned q8.12) with in_valid / in_stall, a transfer
//   happens when in_valid is high and in_stall is low
//   output channel: factor (signed q4.16) and saturated with out_valid /
//   out_stall, same transfer rule
//   configuration: write cfg_data to register cfg_index while cfg_we is high;
//   0 enable, 1 iter_count, 2..5 coefficients of pass 0..3; only while idle
//   each pass holds a 33-stage divider for b / r, a 21-stage divider for the
//   pass quotient and six stages of add, clamp and multiply
//   throughput: one transfer per cycle unless stalled, own hardware per pass
//   reset: pipeline emptied, configuration cleared, block disabled (factor 1.0)
//   stall: an asserted out_stall with a waiting result freezes the whole
//   pipeline and raises in_stall; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module iterative_rational_gain_correction #(
    parameter int MAX_ITER = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [irgc_pkg::XW-1:0]     energy,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [irgc_pkg::FW-1:0] factor,
    output logic                        saturated,
    input  logic                        cfg_we,
    input  logic [irgc_pkg::CFGIW-1:0]  cfg_index,
    input  logic [irgc_pkg::COEFW-1:0]  cfg_data
);

    import irgc_pkg::*;

    // configuration registers
    logic             enable_reg;
    logic [1:0]       iter_count_reg;
    logic [COEFW-1:0] coef_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            iter_count_reg <= 2'd0;
            for (int k = 0; k < 4; k++)
                coef_reg[k] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE: enable_reg     <= cfg_data[0];
                CFG_ITER:   iter_count_reg <= cfg_data[1:0];
                CFG_COEF0:  coef_reg[0]    <= cfg_data;
                CFG_COEF1:  coef_reg[1]    <= cfg_data;
                CFG_COEF2:  coef_reg[2]    <= cfg_data;
                CFG_COEF3:  coef_reg[3]    <= cfg_data;
                default:    ;   // indexes past the list are ignored
            endcase
        end
    end

    // whole pipeline moves unless a finished result is held off
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // entry stage: disabled and zero energy are settled here
    ctx_t ctx0_next;
    logic v_chain   [0:MAX_ITER];
    ctx_t ctx_chain [0:MAX_ITER];
    logic v0_reg;
    ctx_t ctx0_reg;

    always_comb
    begin
        ctx0_next.x     = energy;
        ctx0_next.scale = ONE_Q16;
        ctx0_next.r     = $signed(RW'(energy));
        ctx0_next.sat   = 1'b0;
        ctx0_next.done  = 1'b0;
        if (!enable_reg)
            ctx0_next.done = 1'b1;
        else if (energy == '0)
        begin
            ctx0_next.scale = '0;
            ctx0_next.done  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ctx0_reg <= ctx0_next;
    end

    assign v_chain[0]   = v0_reg;
    assign ctx_chain[0] = ctx0_reg;

    // one pass unit per possible pass
    for (genvar i = 0; i < MAX_ITER; i++)
    begin : g_pass
        localparam int CI = i % 4;
        logic pass_active;

        // pass count is iter_count + 1, never above MAX_ITER
        assign pass_active = ({30'd0, iter_count_reg} >= 32'(i));

        irgc_pass u_pass (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .active  (pass_active),
            .coef    (coef_reg[CI]),
            .in_v    (v_chain[i]),
            .in_ctx  (ctx_chain[i]),
            .out_v   (v_chain[i+1]),
            .out_ctx (ctx_chain[i+1])
        );
    end

    // output register
    logic signed [FW-1:0] factor_reg;
    logic                 saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_chain[MAX_ITER];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            factor_reg    <= ctx_chain[MAX_ITER].scale;
            saturated_reg <= ctx_chain[MAX_ITER].sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign factor    = factor_reg;
    assign saturated = saturated_reg;

endmodule

[tb/sv/irgc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irgc_checker
// watches the energy, factor and configuration ports of the gain correction,
// predicts each factor from its own copy of the registers and compares
// ----------------------------------------------------------------------------
module irgc_checker
    import irgc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [XW-1:0]           energy,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [FW-1:0]    factor,
    input  logic                    saturated,
    input  logic                    cfg_we,
    input  logic [CFGIW-1:0]        cfg_index,
    input  logic [COEFW-1:0]        cfg_data,
    output int                      pending,
    output int                      errors
);

    typedef struct packed {
        logic signed [FW-1:0] factor;
        logic                 sat;
    } gain_t;

    logic              en_q;
    logic [1:0]        iter_q;
    logic [COEFW-1:0]  coef_q [4];
    gain_t             gain_fifo [$];

    localparam longint SMAX = 524287;
    localparam longint SMIN = -524288;

    function automatic longint clamp_scale(longint v, inout bit sat);
        if (v > SMAX)
        begin
            sat = 1'b1;
            return SMAX;
        end
        if (v < SMIN)
        begin
            sat = 1'b1;
            return SMIN;
        end
        return v;
    endfunction

    function automatic gain_t predict_gain(logic [XW-1:0] e);
        longint x, scale, r, a, b, c, num, den, q;
        logic [COEFW-1:0] k;
        bit sat;
        gain_t g;
        x = longint'(e);
        scale = 65536;
        r = x;
        sat = 1'b0;
        if (!en_q)
        begin
            g.factor = ONE_Q16;
            g.sat = 1'b0;
            return g;
        end
        if (x == 0)
        begin
            g.factor = '0;
            g.sat = 1'b0;
            return g;
        end
        for (int i = 0; i <= int'(iter_q); i++)
        begin
            if (r == 0)
                break;
            k = coef_q[i & 3];
            a = longint'($signed(k[15:0]));
            b = longint'($signed(k[31:16]));
            c = longint'($signed(k[47:32]));
            num = r + a * 16 + (b * 65536) / r;
            den = r + c * 16;
            if (den == 0)
            begin
                sat = 1'b1;
                scale = ((num < 0) != (scale < 0)) ? SMIN : SMAX;
                break;
            end
            q = clamp_scale((num * 65536) / den, sat);
            // arithmetic shift of a signed value rounds toward minus infinity
            scale = clamp_scale((scale * q) >>> 16, sat);
            r = (x * scale) >>> 16;
        end
        g.factor = scale[FW-1:0];
        g.sat = sat;
        return g;
    endfunction

    assign pending = gain_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        gain_t want;
        int    bad;
        bad = 0;
        if (!rst_n)
        begin
            en_q <= 1'b0;
            iter_q <= '0;
            for (int i = 0; i < 4; i++)
                coef_q[i] <= '0;
            gain_fifo.delete();
            errors <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE: en_q <= cfg_data[0];
                    CFG_ITER:   iter_q <= cfg_data[1:0];
                    CFG_COEF0:  coef_q[0] <= cfg_data;
                    CFG_COEF1:  coef_q[1] <= cfg_data;
                    CFG_COEF2:  coef_q[2] <= cfg_data;
                    CFG_COEF3:  coef_q[3] <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (gain_fifo.size() == 0)
                begin
                    $error("factor transfer with nothing expected: %0d", factor);
                    bad++;
                end
                else
                begin
                    want = gain_fifo.pop_front();
                    if (factor !== want.factor)
                    begin
                        $error("factor: expected %0d, got %0d", want.factor, factor);
                        bad++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated: expected %0d, got %0d", want.sat, saturated);
                        bad++;
                    end
                end
            end
            if (in_valid && !in_stall)
                gain_fifo.push_back(predict_gain(energy));
            errors <= errors + bad;
        end
    end

endmodule

[tb/sv/tb_iterative_rational_gain_correction.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iterative_rational_gain_correction
// drives energy transfers in bursts through several register settings while
// the output side stalls at random; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_iterative_rational_gain_correction;
    import irgc_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [XW-1:0]          energy;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [FW-1:0]   factor;
    logic                   saturated;
    logic                   cfg_we;
    logic [CFGIW-1:0]       cfg_index;
    logic [COEFW-1:0]       cfg_data;
    logic                   press_req;
    int                     pending;
    int                     errors;

    // pipeline depth at four passes, plus margin
    localparam int DRAIN = 260;

    iterative_rational_gain_correction dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .energy(energy),
        .out_valid(out_valid), .out_stall(out_stall),
        .factor(factor), .saturated(saturated),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    irgc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .energy(energy),
        .out_valid(out_valid), .out_stall(out_stall),
        .factor(factor), .saturated(saturated),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #4ms;
        $display("tb_iterative_rational_gain_correction: done, errors");
        $finish;
    end

    // receiver: stall pattern in stretches of changing density, plus one long
    // hold-off while the sender keeps offering, so the pipeline fills and
    // pushes back on the input
    initial
    begin
        int mode;
        int span;
        int hold;
        bit press_seen;
        out_stall = 1'b0;
        press_seen = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 120);
            hold = 0;
            if (press_req && !press_seen)
            begin
                hold = 700;
                press_seen = 1'b1;
            end
            repeat (hold)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
            end
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // write enable stays up across a run of writes; the caller drops it
    task automatic reg_write(input logic [CFGIW-1:0] idx, input logic [COEFW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // sender holds valid across back-to-back transfers and only drops it in a gap
    task automatic send_energy(input logic [XW-1:0] e);
        in_valid <= 1'b1;
        energy <= e;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pause_sender(input int n);
        in_valid <= 1'b0;
        energy <= XW'($urandom());
        repeat (n) @(posedge clk);
    endtask

    // wait until every factor is back, then let the pipeline settle
    task automatic drain_pipe();
        pause_sender(1);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_setting(input logic en, input logic [1:0] iters,
                                input logic [COEFW-1:0] k0, input logic [COEFW-1:0] k1,
                                input logic [COEFW-1:0] k2, input logic [COEFW-1:0] k3);
        drain_pipe();
        reg_write(CFG_ENABLE, {{(COEFW-1){1'b1}}, en});
        reg_write(CFG_ITER, {{(COEFW-2){1'b0}}, iters});
        reg_write(CFG_COEF0, k0);
        reg_write(CFG_COEF1, k1);
        reg_write(CFG_COEF2, k2);
        reg_write(CFG_COEF3, k3);
        cfg_we <= 1'b0;
    endtask

    // coefficient half near a useful magnitude, at an extreme, or fully random
    function automatic logic [15:0] coef_half();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            2: return 16'($signed($urandom_range(0, 16383)) - 8192);
            default: return 16'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7FFF);
        endcase
    endfunction

    function automatic logic [COEFW-1:0] coef_set();
        return {coef_half(), coef_half(), coef_half()};
    endfunction

    function automatic logic [XW-1:0] pick_energy();
        case ($urandom_range(0, 5))
            0: return XW'($urandom());
            1: return XW'($urandom_range(0, 255));
            2: return 20'($urandom_range(0, 4095)) << 4;
            3: return 20'($urandom_range(1, 16));
            4: return XW'($urandom_range(4096, 65535));
            default: return $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
        endcase
    endfunction

    initial
    begin
        int burst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        energy = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        press_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: disabled, factor is exactly one whatever the energy
        send_energy(20'h0);
        send_energy(20'hFFFFF);
        send_energy(20'h01000);

        // writes to indexes past the register list must change nothing
        drain_pipe();
        reg_write(3'd6, '1);
        reg_write(3'd7, '1);
        cfg_we <= 1'b0;
        send_energy(20'h12345);

        // one pass, zero denominator: c = -1.0 against x = 1.0, both signs of num
        load_setting(1'b1, 2'd0, {16'hFF00, 16'h0000, 16'h0000},
                     '0, '0, '0);
        send_energy(20'h01000);
        send_energy(20'h0);
        send_energy(20'h00001);
        send_energy(20'hFFFFF);
        load_setting(1'b1, 2'd0, {16'hFF00, 16'h0000, 16'hFE00}, '0, '0, '0);
        send_energy(20'h01000);

        // pass quotient overflow: den of 16 against a large num
        load_setting(1'b1, 2'd0, {16'hFF01, 16'h0000, 16'h0000}, '0, '0, '0);
        send_energy(20'h01000);

        // scale collapses to zero, next pass sees a zero reference
        load_setting(1'b1, 2'd3, {16'h0000, 16'h0000, 16'hFF00},
                     {16'h0100, 16'h0100, 16'h0100}, '1, '1);
        send_energy(20'h01000);
        send_energy(20'h00800);

        // all four passes at the coefficient extremes
        load_setting(1'b1, 2'd3, {16'h7FFF, 16'h7FFF, 16'h7FFF},
                     {16'h8000, 16'h8000, 16'h8000},
                     {16'h0000, 16'h8000, 16'h7FFF}, '1);
        send_energy(20'h00001);
        send_energy(20'hFFFFF);
        send_energy(20'h80000);
        send_energy(20'h7FFFF);

        // long receiver hold-off while more transfers are offered than the
        // pipeline can take
        drain_pipe();
        press_req <= 1'b1;
        for (int n = 0; n < 400; n++)
            send_energy(pick_energy());
        press_req <= 1'b0;

        // random part: a new setting every phase, mostly enabled
        for (int ph = 0; ph < 12; ph++)
        begin
            load_setting($urandom_range(0, 5) != 0, 2'($urandom_range(0, 3)),
                         coef_set(), coef_set(), coef_set(), coef_set());
            for (int n = 0; n < 83; )
            begin
                burst = $urandom_range(1, 40);
                for (int j = 0; j < burst && n < 83; j++, n++)
                    send_energy(pick_energy());
                if ($urandom_range(0, 2) != 0)
                    pause_sender($urandom_range(1, 12));
            end
        end

        pause_sender(1);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("tb_iterative_rational_gain_correction: done, clean");
        else
            $display("tb_iterative_rational_gain_correction: done, errors");
        $finish;
    end

endmodule
